// ===== src/mlr_pkg.sv =====
// Shared types for the midpoint line rasterizer.
// Controller/datapath command and status structs; no dependencies.
`default_nettype none

package mlr_pkg;

  // guard bits on top of the coordinate width for the decision variable
  localparam int unsigned DEC_EXTRA_BITS = 4;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic last;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/mlr_if.sv =====
// Request channel interfaces: line segment in, pixel out.
// Valid/ready handshake; width set by COORD_BITS. No dependencies.
`default_nettype none

interface mlr_seg_if #(
  parameter int unsigned COORD_BITS = 6
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;

  modport source (output valid, output x_start, output y_start, output x_end, output y_end,
                  input ready);
  modport sink (input valid, input x_start, input y_start, input x_end, input y_end,
                output ready);
endinterface

interface mlr_pix_if #(
  parameter int unsigned COORD_BITS = 6
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  last_pixel;

  modport source (output valid, output pixel_x, output pixel_y, output last_pixel,
                  input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input last_pixel,
                output ready);
endinterface

`default_nettype wire

// ===== src/midpoint_line_rasterizer.sv =====
// Midpoint line rasterizer top level: controller plus datapath.
// Depends on mlr_pkg, mlr_if, mlr_ctrl and mlr_dp.
//
// Usage:
//   seg_i takes one line segment per request (two endpoints, COORD_BITS each).
//   pix_o returns every pixel of that line, in order from the endpoint with
//   the smaller x, one request per pixel; last_pixel marks the final one.
//   A segment yields max(|dx|, |dy|) + 1 pixels, at most 2^COORD_BITS.
// Timing:
//   The first pixel is valid in the cycle after the segment is accepted; each
//   next pixel follows in the cycle after the previous one is accepted, set
//   by the single-step decision update in the datapath. seg_i is ready
//   again the cycle after the last pixel is taken.
// Reset and stall:
//   After reset the block is idle with seg_i.ready high. When the receiver
//   holds pix_o.ready low, the current pixel holds and stepping stops.
`default_nettype none

module midpoint_line_rasterizer #(
  parameter int unsigned COORD_BITS = 6
) (
  input logic       clk_i,
  input logic       rst_ni,
  mlr_seg_if.sink   seg_i,
  mlr_pix_if.source pix_o
);
  import mlr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mlr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (seg_i.valid),
    .in_ready_o  (seg_i.ready),
    .out_valid_o (pix_o.valid),
    .out_ready_i (pix_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mlr_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .x_start_i    (seg_i.x_start),
    .y_start_i    (seg_i.y_start),
    .x_end_i      (seg_i.x_end),
    .y_end_i      (seg_i.y_end),
    .pixel_x_o    (pix_o.pixel_x),
    .pixel_y_o    (pix_o.pixel_y),
    .last_pixel_o (pix_o.last_pixel)
  );

endmodule

`default_nettype wire

// ===== src/mlr_ctrl.sv =====
// Controller FSM of the line rasterizer: handshakes and datapath commands.
// Depends on mlr_pkg.
`default_nettype none

module mlr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  mlr_pkg::sts_t sts_i,
  output mlr_pkg::cmd_t cmd_o
);
  import mlr_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   in_acc;
  logic   out_acc;

  assign in_acc      = in_valid_i & in_ready_q;
  assign out_acc     = out_valid_q & out_ready_i;
  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;
  assign cmd_o.load  = in_acc;
  assign cmd_o.step  = out_acc & ~sts_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q     <= S_EMIT;
            in_ready_q  <= 1'b0;
            out_valid_q <= 1'b1;
          end
        end
        S_EMIT: begin
          if (out_acc && sts_i.last) begin
            state_q     <= S_IDLE;
            in_ready_q  <= 1'b1;
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_q && out_valid_q))
    else $error("input ready while a pixel is pending");

  a_load_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("no pixel after segment load");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && sts_i.last) |=> (in_ready_q && !out_valid_q))
    else $error("not idle after last pixel");

  a_step_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |=> out_valid_q)
    else $error("stepped past the last pixel");

endmodule

`default_nettype wire

// ===== src/mlr_dp.sv =====
// Datapath of the line rasterizer: endpoint ordering, slope class,
// decision variable and pixel stepping. Depends on mlr_pkg.
`default_nettype none

module mlr_dp #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mlr_pkg::cmd_t         cmd_i,
  output mlr_pkg::sts_t         sts_o,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  last_pixel_o
);
  import mlr_pkg::*;

  localparam int unsigned DW = COORD_BITS + DEC_EXTRA_BITS;

  typedef enum logic [1:0] {
    CLS_SHALLOW_UP,
    CLS_SHALLOW_DN,
    CLS_STEEP_UP,
    CLS_STEEP_DN
  } cls_e;

  logic                  swap;
  logic [COORD_BITS-1:0] xa, ya, xb, yb;
  logic signed [DW-1:0]  dx_s, dy_s, ady_s, a_s, b_s;
  logic signed [DW-1:0]  d0, dstr0, ddia0;
  cls_e                  cls0;
  logic [COORD_BITS-1:0] cnt0;

  logic [COORD_BITS-1:0] x_q, y_q, cnt_q;
  logic signed [DW-1:0]  d_q, dstr_q, ddia_q;
  cls_e                  cls_q;

  logic                  diag;
  logic [COORD_BITS-1:0] x_d, y_d;
  logic signed [DW-1:0]  d_d;

  always_comb begin
    swap  = x_end_i < x_start_i;
    xa    = swap ? x_end_i   : x_start_i;
    ya    = swap ? y_end_i   : y_start_i;
    xb    = swap ? x_start_i : x_end_i;
    yb    = swap ? y_start_i : y_end_i;
    dx_s  = signed'(DW'(xb)) - signed'(DW'(xa));
    dy_s  = signed'(DW'(yb)) - signed'(DW'(ya));
    ady_s = (dy_s < 0) ? -dy_s : dy_s;
    a_s   = -dy_s;
    b_s   = dx_s;
    cnt0  = (dx_s > ady_s) ? dx_s[COORD_BITS-1:0] : ady_s[COORD_BITS-1:0];
    if (dx_s > ady_s && dy_s >= 0) begin
      cls0  = CLS_SHALLOW_UP;
      d0    = a_s + a_s + b_s;
      dstr0 = a_s + a_s;
      ddia0 = a_s + b_s + a_s + b_s;
    end else if (dx_s > ady_s) begin
      cls0  = CLS_SHALLOW_DN;
      d0    = a_s + a_s - b_s;
      dstr0 = a_s + a_s;
      ddia0 = a_s - b_s + a_s - b_s;
    end else if (dy_s < 0) begin
      cls0  = CLS_STEEP_DN;
      d0    = a_s - b_s - b_s;
      dstr0 = -(b_s + b_s);
      ddia0 = a_s - b_s + a_s - b_s;
    end else begin
      cls0  = CLS_STEEP_UP;
      d0    = a_s + b_s + b_s;
      dstr0 = b_s + b_s;
      ddia0 = a_s + b_s + a_s + b_s;
    end
  end

  always_comb begin
    case (cls_q)
      CLS_SHALLOW_UP: begin
        diag = d_q < 0;
        x_d  = x_q + 1'b1;
        y_d  = y_q + COORD_BITS'(diag);
      end
      CLS_SHALLOW_DN: begin
        diag = d_q > 0;
        x_d  = x_q + 1'b1;
        y_d  = y_q - COORD_BITS'(diag);
      end
      CLS_STEEP_UP: begin
        diag = d_q > 0;
        x_d  = x_q + COORD_BITS'(diag);
        y_d  = y_q + 1'b1;
      end
      CLS_STEEP_DN: begin
        diag = d_q < 0;
        x_d  = x_q + COORD_BITS'(diag);
        y_d  = y_q - 1'b1;
      end
      default: begin
        diag = 1'b0;
        x_d  = x_q;
        y_d  = y_q;
      end
    endcase
    d_d = diag ? d_q + ddia_q : d_q + dstr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= cnt0;
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q    <= xa;
      y_q    <= ya;
      d_q    <= d0;
      dstr_q <= dstr0;
      ddia_q <= ddia0;
      cls_q  <= cls0;
    end else if (cmd_i.step) begin
      x_q <= x_d;
      y_q <= y_d;
      d_q <= d_d;
    end
  end

  assign sts_o.last   = (cnt_q == '0);
  assign pixel_x_o    = x_q;
  assign pixel_y_o    = y_q;
  assign last_pixel_o = sts_o.last;

endmodule

`default_nettype wire
